// ===== hdl/qrs_pkg.sv =====
// Shared types, widths and status codes for the quadratic root solver.
`timescale 1ns / 1ps
package qrs_pkg;

    localparam int CoefWidth = 16;
    localparam int RadWidth  = 34;   // discriminant, padded to an even width
    localparam int RootWidth = RadWidth / 2;
    localparam int SqRemW    = RootWidth + 2;
    localparam int DvdWidth  = 34;   // |num| (18 bits) shifted by 16
    localparam int DenWidth  = CoefWidth + 1;
    localparam int SqCells   = RootWidth;
    localparam int DivCells  = DvdWidth;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_A_ZERO   = 2'd1;
    localparam logic [1:0] ST_NEG_DISC = 2'd2;

    // Item moving through the square-root cells
    typedef struct packed {
        logic                        vld;
        logic [1:0]                  status;
        logic signed [CoefWidth-1:0] a;
        logic signed [CoefWidth-1:0] b;
        logic [RadWidth-1:0]         rad;
        logic [SqRemW-1:0]           rem;
        logic [RootWidth-1:0]        root;
    } sq_t;

    // Item moving through the divider cells (both roots side by side)
    typedef struct packed {
        logic                  vld;
        logic [1:0]            status;
        logic                  neg_p;
        logic                  neg_m;
        logic [DenWidth-1:0]   den;
        logic [DvdWidth-1:0]   dq_p;
        logic [DvdWidth-1:0]   dq_m;
        logic [DenWidth-1:0]   rem_p;
        logic [DenWidth-1:0]   rem_m;
    } dv_t;

endpackage

// ===== hdl/qrs_sqrt_cell.sv =====
// One square-root cell: settles one root bit from two radicand bits.
`timescale 1ns / 1ps
module qrs_sqrt_cell
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  qrs_pkg::sq_t d,
    output qrs_pkg::sq_t q
);
    import qrs_pkg::*;

    sq_t                  q_reg;
    sq_t                  q_next;
    logic [SqRemW+1:0]    r2;
    logic [SqRemW+1:0]    trial;
    logic                 take;

    // Restoring step: bring down two bits, try subtracting 4*root+1
    always_comb
    begin
        r2     = {d.rem, d.rad[RadWidth-1 -: 2]};
        trial  = (SqRemW + 2)'({d.root, 2'b01});
        take   = (r2 >= trial);
        q_next = d;
        q_next.rad  = {d.rad[RadWidth-3:0], 2'b00};
        q_next.rem  = take ? SqRemW'(r2 - trial) : SqRemW'(r2);
        q_next.root = {d.root[RootWidth-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_reg <= '0;
        else if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ===== hdl/qrs_div_cell.sv =====
// One divider cell: settles one quotient bit for each of the two roots.
`timescale 1ns / 1ps
module qrs_div_cell
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  qrs_pkg::dv_t d,
    output qrs_pkg::dv_t q
);
    import qrs_pkg::*;

    dv_t               q_reg;
    dv_t               q_next;
    logic [DenWidth:0] r2_p;
    logic [DenWidth:0] r2_m;
    logic [DenWidth:0] den_x;
    logic              take_p;
    logic              take_m;

    // Restoring step on both dividends against the shared divisor
    always_comb
    begin
        den_x  = {1'b0, d.den};
        r2_p   = {d.rem_p, d.dq_p[DvdWidth-1]};
        r2_m   = {d.rem_m, d.dq_m[DvdWidth-1]};
        take_p = (r2_p >= den_x);
        take_m = (r2_m >= den_x);
        q_next = d;
        q_next.rem_p = take_p ? DenWidth'(r2_p - den_x) : DenWidth'(r2_p);
        q_next.rem_m = take_m ? DenWidth'(r2_m - den_x) : DenWidth'(r2_m);
        q_next.dq_p  = {d.dq_p[DvdWidth-2:0], take_p};
        q_next.dq_m  = {d.dq_m[DvdWidth-2:0], take_m};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_reg <= '0;
        else if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ===== hdl/quadratic_root_solver.sv =====
// Top level: pipelined real-root solver for a*x^2 + b*x + c.
// Input channel in_valid/in_ready carries coef_a, coef_b, coef_c (signed Q8.8).
// Output channel out_valid/out_ready carries root_plus, root_minus (signed
// Q16.16, truncated toward zero, saturated) and status (0 ok, 1 a is zero,
// 2 negative discriminant; roots are zero when status is nonzero).
// Pipeline: input register, two multipliers, discriminant add, 17 square-root
// cells, numerator stage, 34 divider cells and an output register.
// One item is taken every cycle while the output is not stalled.
// The depth is set by the square-root and divider cell chains, one bit each.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops; nothing is lost or duplicated.
// Reset clears every valid bit, so the pipeline comes up empty.
`timescale 1ns / 1ps
module quadratic_root_solver
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [qrs_pkg::CoefWidth-1:0]  coef_a,
    input  logic signed [qrs_pkg::CoefWidth-1:0]  coef_b,
    input  logic signed [qrs_pkg::CoefWidth-1:0]  coef_c,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [31:0]                    root_plus,
    output logic signed [31:0]                    root_minus,
    output logic [1:0]                            status
);
    import qrs_pkg::*;

    logic en;

    // Input register
    logic                        v0_reg;
    logic signed [CoefWidth-1:0] a0_reg, b0_reg, c0_reg;
    // Product register
    logic                        v1_reg;
    logic signed [CoefWidth-1:0] a1_reg, b1_reg;
    logic signed [31:0]          bb1_reg, ac1_reg;
    // Discriminant
    logic signed [34:0]          disc;
    sq_t                         sq_next;
    sq_t                         sq_reg;
    sq_t                         sq_chain [SqCells+1];
    // Numerator
    logic signed [18:0]          np, nm;
    logic signed [18:0]          np_abs, nm_abs;
    logic signed [DenWidth-1:0]  den_s;
    dv_t                         dv_next;
    dv_t                         dv_reg;
    dv_t                         dv_chain [DivCells+1];
    dv_t                         dv_last;
    // Output
    logic                        out_valid_reg;
    logic [31:0]                 rp_reg, rm_reg, rp_next, rm_next;
    logic [1:0]                  status_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // Input and product stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg  <= coef_a;
            b0_reg  <= coef_b;
            c0_reg  <= coef_c;
            a1_reg  <= a0_reg;
            b1_reg  <= b0_reg;
            bb1_reg <= 32'(b0_reg) * 32'(b0_reg);
            ac1_reg <= 32'(a0_reg) * 32'(c0_reg);
        end
    end

    // Discriminant and status
    always_comb
    begin
        disc    = 35'(bb1_reg) - (35'(ac1_reg) <<< 2);
        sq_next = '0;
        sq_next.vld = v1_reg;
        sq_next.a   = a1_reg;
        sq_next.b   = b1_reg;
        if (a1_reg == '0)
            sq_next.status = ST_A_ZERO;
        else if (disc[34])
            sq_next.status = ST_NEG_DISC;
        else
        begin
            sq_next.status = ST_OK;
            sq_next.rad    = disc[RadWidth-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_reg <= '0;
        else if (en)
            sq_reg <= sq_next;
    end

    // Square-root cell chain
    assign sq_chain[0] = sq_reg;
    for (genvar i = 0; i < SqCells; i++)
    begin : g_sq
        qrs_sqrt_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d     (sq_chain[i]),
            .q     (sq_chain[i+1])
        );
    end

    // Numerators, signs and magnitudes
    always_comb
    begin
        np      = -19'(sq_chain[SqCells].b) + 19'($signed({1'b0, sq_chain[SqCells].root}));
        nm      = -19'(sq_chain[SqCells].b) - 19'($signed({1'b0, sq_chain[SqCells].root}));
        np_abs  = np[18] ? -np : np;
        nm_abs  = nm[18] ? -nm : nm;
        den_s   = {sq_chain[SqCells].a, 1'b0};
        dv_next = '0;
        dv_next.vld    = sq_chain[SqCells].vld;
        dv_next.status = sq_chain[SqCells].status;
        dv_next.neg_p  = np[18] ^ den_s[DenWidth-1];
        dv_next.neg_m  = nm[18] ^ den_s[DenWidth-1];
        dv_next.den    = den_s[DenWidth-1] ? DenWidth'(-den_s) : DenWidth'(den_s);
        dv_next.dq_p   = {np_abs[17:0], 16'b0};
        dv_next.dq_m   = {nm_abs[17:0], 16'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg <= '0;
        else if (en)
            dv_reg <= dv_next;
    end

    // Divider cell chain
    assign dv_chain[0] = dv_reg;
    for (genvar j = 0; j < DivCells; j++)
    begin : g_dv
        qrs_div_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d     (dv_chain[j]),
            .q     (dv_chain[j+1])
        );
    end

    assign dv_last = dv_chain[DivCells];

    // Sign, saturation and status gating
    always_comb
    begin
        if (dv_last.status != ST_OK)
            rp_next = '0;
        else if (dv_last.neg_p)
            rp_next = (dv_last.dq_p > 34'h080000000) ? 32'h80000000
                                                     : 32'(-dv_last.dq_p);
        else
            rp_next = (dv_last.dq_p > 34'h07fffffff) ? 32'h7fffffff
                                                     : dv_last.dq_p[31:0];

        if (dv_last.status != ST_OK)
            rm_next = '0;
        else if (dv_last.neg_m)
            rm_next = (dv_last.dq_m > 34'h080000000) ? 32'h80000000
                                                     : 32'(-dv_last.dq_m);
        else
            rm_next = (dv_last.dq_m > 34'h07fffffff) ? 32'h7fffffff
                                                     : dv_last.dq_m[31:0];
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_last.vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rp_reg     <= rp_next;
            rm_reg     <= rm_next;
            status_reg <= dv_last.status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign root_plus  = rp_reg;
    assign root_minus = rm_reg;
    assign status     = status_reg;

endmodule
